// ===== rtl/core/stgd_pkg.sv =====
package stgd_pkg;

	// Fixed-point layout
	localparam int COEFF_FRAC_BITS = 24;
	localparam int COEFF_W         = 24;
	localparam int AMT_W           = 16;
	localparam int SAMPLE_W        = 16;
	localparam int GAIN_W          = 16;
	localparam int ENV_W           = 32;
	localparam int DEN_W           = ENV_W + 1;

	// Shared multiplier: signed coefficient side times signed difference side
	localparam int MUL_A_W = COEFF_W + 1;
	localparam int MUL_B_W = ENV_W + 2;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int UPD_W   = PROD_W - COEFF_FRAC_BITS;
	localparam int SUM_W   = ((UPD_W > MUL_B_W) ? UPD_W : MUL_B_W) + 1;

	// Ratio divider: Q.16 quotient, known below 2^18 once saturation is ruled out
	localparam int RATIO_W   = 17;
	localparam int DIV_STEPS = 18;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DEN_W-1:0]   OFFSET_Q31 = DEN_W'(42949673);
	localparam logic [RATIO_W-1:0] RATIO_MAX  = RATIO_W'(98304);
	localparam logic [RATIO_W-1:0] K_FULL     = RATIO_W'(58982);
	localparam logic [RATIO_W-1:0] K_LOW      = RATIO_W'(72090);
	localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0]  GAIN_MAX   = GAIN_W'(36045);

	// Weighted sum: amount * k * ratio, Q.47
	localparam int WSUM_W    = AMT_W + RATIO_W + RATIO_W;
	localparam int GAIN_SHIFT = 33;

	// Register file
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_FAST_ATTACK  = 3'd0,
		REG_FAST_RELEASE = 3'd1,
		REG_SLOW_ATTACK  = 3'd2,
		REG_SLOW_RELEASE = 3'd3,
		REG_LOWPASS      = 3'd4,
		REG_PUNCH        = 3'd5,
		REG_TRANSIENT    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [ENV_W-1:0] fast;
		logic [ENV_W-1:0] slow;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [RATIO_W-1:0] ratio;
	} div_rsp_t;

endpackage

// ===== rtl/core/stgd_div.sv =====
module stgd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  stgd_pkg::div_req_t req,
	output stgd_pkg::div_rsp_t rsp
);

	typedef enum logic [0:0] {
		D_IDLE,
		D_STEP
	} dstate_t;

	dstate_t                             state_q;
	logic [stgd_pkg::DEN_W-1:0]          den_q;
	logic [stgd_pkg::DEN_W-1:0]          rem_q;
	logic [stgd_pkg::DIV_STEPS-1:0]      num_q;
	logic [stgd_pkg::DIV_STEPS-1:0]      quo_q;
	logic [stgd_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic                                done_q;
	logic [stgd_pkg::RATIO_W-1:0]        ratio_q;

	logic [stgd_pkg::ENV_W-1:0]          diff;
	logic [stgd_pkg::DEN_W-1:0]          den;
	logic                                sat;
	logic [stgd_pkg::DEN_W:0]            trial;
	logic [stgd_pkg::DEN_W:0]            trial_sub;
	logic                                take;
	logic [stgd_pkg::DIV_STEPS-1:0]      quo_nx;

	always_comb begin
		diff = (req.fast > req.slow) ? (req.fast - req.slow) : '0;
		den  = stgd_pkg::DEN_W'(req.slow) + stgd_pkg::OFFSET_Q31;
		// quotient would need more than 18 bits: 1.5 clamp applies anyway
		sat  = {3'b000, diff} >= {den, 2'b00};
		trial     = {rem_q, num_q[stgd_pkg::DIV_STEPS-1]};
		trial_sub = trial - {1'b0, den_q};
		take      = trial >= {1'b0, den_q};
		quo_nx    = {quo_q[stgd_pkg::DIV_STEPS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			ratio_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						if (sat) begin
							ratio_q <= stgd_pkg::RATIO_MAX;
							done_q  <= 1'b1;
						end else begin
							den_q   <= den;
							rem_q   <= stgd_pkg::DEN_W'(diff[stgd_pkg::ENV_W-1:2]);
							num_q   <= {diff[1:0], 16'h0000};
							quo_q   <= '0;
							cnt_q   <= '0;
							state_q <= D_STEP;
						end
					end
				end
				D_STEP: begin
					if (take) begin
						rem_q <= trial_sub[stgd_pkg::DEN_W-1:0];
					end else begin
						rem_q <= trial[stgd_pkg::DEN_W-1:0];
					end
					num_q <= {num_q[stgd_pkg::DIV_STEPS-2:0], 1'b0};
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stgd_pkg::DIV_CNT_W'(stgd_pkg::DIV_STEPS - 1)) begin
						if (quo_nx > stgd_pkg::DIV_STEPS'(stgd_pkg::RATIO_MAX)) begin
							ratio_q <= stgd_pkg::RATIO_MAX;
						end else begin
							ratio_q <= quo_nx[stgd_pkg::RATIO_W-1:0];
						end
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.ratio = ratio_q;

endmodule

// ===== rtl/core/stereo_transient_gain_detector.sv =====
// Stereo transient gain detector. Each transfer on the input channel takes one
// Q1.15 left/right pair and yields one Q2.14 gain between 1.0 and 2.2. Per pair the
// block runs the five envelope and lowpass updates on one shared multiplier, two
// 18-step restoring divisions for the ratios (a ratio of 4.0 or more skips the
// steps and is clamped to 1.5 at once), and four multiplier passes plus a final
// sum and clamp for the weighted gain. in_ready is high only while idle; a finished
// gain waits in the output register, so the next pair is taken even if the previous
// gain has not been picked up. Coefficient and amount registers are written through
// the APB port and are read back zero-extended from their 24 or 16 bits.
module stereo_transient_gain_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [stgd_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [stgd_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [stgd_pkg::GAIN_W-1:0]          gain,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [stgd_pkg::PADDR_W-1:0]         paddr,
	input  logic [stgd_pkg::PDATA_W-1:0]         pwdata,
	output logic [stgd_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FMUL,
		S_FACC,
		S_DIV_START,
		S_DIV_WAIT,
		S_W1F,
		S_W2F,
		S_W1L,
		S_W2L,
		S_GAIN
	} state_t;

	typedef enum logic [2:0] {
		F_FULL_FAST,
		F_FULL_SLOW,
		F_LOWPASS,
		F_LOW_FAST,
		F_LOW_SLOW
	} filt_t;

	// configuration
	logic [stgd_pkg::COEFF_W-1:0] fast_attack_q;
	logic [stgd_pkg::COEFF_W-1:0] fast_release_q;
	logic [stgd_pkg::COEFF_W-1:0] slow_attack_q;
	logic [stgd_pkg::COEFF_W-1:0] slow_release_q;
	logic [stgd_pkg::COEFF_W-1:0] lowpass_coeff_q;
	logic [stgd_pkg::AMT_W-1:0]   punch_amount_q;
	logic [stgd_pkg::AMT_W-1:0]   transient_amount_q;

	// state
	logic [stgd_pkg::ENV_W-1:0]        env_full_fast_q;
	logic [stgd_pkg::ENV_W-1:0]        env_full_slow_q;
	logic [stgd_pkg::ENV_W-1:0]        env_low_fast_q;
	logic [stgd_pkg::ENV_W-1:0]        env_low_slow_q;
	logic signed [stgd_pkg::ENV_W-1:0] lowpass_level_q;

	// sequencer and datapath
	state_t                              state_q;
	filt_t                               sel_q;
	logic                                div_low_q;
	logic [stgd_pkg::ENV_W-1:0]          mag_q;
	logic signed [stgd_pkg::ENV_W-1:0]   mid_q;
	logic signed [stgd_pkg::PROD_W-1:0]  prod_q;
	logic [stgd_pkg::WSUM_W-1:0]         wsum_q;
	logic [stgd_pkg::RATIO_W-1:0]        rf_q;
	logic [stgd_pkg::RATIO_W-1:0]        rl_q;
	logic                                out_valid_q;
	logic [stgd_pkg::GAIN_W-1:0]         gain_q;

	logic                                in_xfer;
	logic                                cfg_wr;
	logic [2:0]                          cfg_idx;
	logic [stgd_pkg::SAMPLE_W-1:0]       abs_l;
	logic [stgd_pkg::SAMPLE_W-1:0]       abs_r;
	logic signed [stgd_pkg::SAMPLE_W:0]  lr_sum;
	logic [stgd_pkg::ENV_W-1:0]          low_mag;
	logic signed [stgd_pkg::MUL_B_W-1:0] target;
	logic signed [stgd_pkg::MUL_B_W-1:0] level;
	logic signed [stgd_pkg::MUL_B_W-1:0] delta;
	logic [stgd_pkg::COEFF_W-1:0]        coeff;
	logic signed [stgd_pkg::MUL_A_W-1:0] mul_a;
	logic signed [stgd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [stgd_pkg::UPD_W-1:0]   upd;
	logic signed [stgd_pkg::SUM_W-1:0]   new_level;
	logic [stgd_pkg::ENV_W-1:0]          env_sat;
	logic signed [stgd_pkg::ENV_W-1:0]  lp_sat;
	logic [stgd_pkg::WSUM_W:0]           total;
	logic [stgd_pkg::WSUM_W-stgd_pkg::GAIN_SHIFT:0] gain_raw;
	stgd_pkg::div_req_t                  div_req;
	stgd_pkg::div_rsp_t                  div_rsp;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign gain      = gain_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign cfg_idx   = paddr[stgd_pkg::PADDR_W-1:2];

	always_comb begin
		case (cfg_idx)
			stgd_pkg::REG_FAST_ATTACK:  prdata = stgd_pkg::PDATA_W'(fast_attack_q);
			stgd_pkg::REG_FAST_RELEASE: prdata = stgd_pkg::PDATA_W'(fast_release_q);
			stgd_pkg::REG_SLOW_ATTACK:  prdata = stgd_pkg::PDATA_W'(slow_attack_q);
			stgd_pkg::REG_SLOW_RELEASE: prdata = stgd_pkg::PDATA_W'(slow_release_q);
			stgd_pkg::REG_LOWPASS:      prdata = stgd_pkg::PDATA_W'(lowpass_coeff_q);
			stgd_pkg::REG_PUNCH:        prdata = stgd_pkg::PDATA_W'(punch_amount_q);
			stgd_pkg::REG_TRANSIENT:    prdata = stgd_pkg::PDATA_W'(transient_amount_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		// magnitude of -1.0 wraps to 0x8000, which reads correctly as unsigned
		abs_l   = left_sample[stgd_pkg::SAMPLE_W-1] ? (-left_sample) : left_sample;
		abs_r   = right_sample[stgd_pkg::SAMPLE_W-1] ? (-right_sample) : right_sample;
		lr_sum  = (stgd_pkg::SAMPLE_W + 1)'(left_sample) + (stgd_pkg::SAMPLE_W + 1)'(right_sample);
		low_mag = lowpass_level_q[stgd_pkg::ENV_W-1] ? (-lowpass_level_q) : lowpass_level_q;
	end

	// Filter operand selection
	always_comb begin
		case (sel_q)
			F_FULL_FAST: begin
				target = $signed(stgd_pkg::MUL_B_W'(mag_q));
				level  = $signed(stgd_pkg::MUL_B_W'(env_full_fast_q));
			end
			F_FULL_SLOW: begin
				target = $signed(stgd_pkg::MUL_B_W'(mag_q));
				level  = $signed(stgd_pkg::MUL_B_W'(env_full_slow_q));
			end
			F_LOWPASS: begin
				target = stgd_pkg::MUL_B_W'(mid_q);
				level  = stgd_pkg::MUL_B_W'(lowpass_level_q);
			end
			F_LOW_FAST: begin
				target = $signed(stgd_pkg::MUL_B_W'(low_mag));
				level  = $signed(stgd_pkg::MUL_B_W'(env_low_fast_q));
			end
			F_LOW_SLOW: begin
				target = $signed(stgd_pkg::MUL_B_W'(low_mag));
				level  = $signed(stgd_pkg::MUL_B_W'(env_low_slow_q));
			end
			default: begin
				target = '0;
				level  = '0;
			end
		endcase
		delta = target - level;
		case (sel_q)
			F_FULL_FAST, F_LOW_FAST: coeff = (delta > 0) ? fast_attack_q : fast_release_q;
			F_FULL_SLOW, F_LOW_SLOW: coeff = (delta > 0) ? slow_attack_q : slow_release_q;
			default:                 coeff = lowpass_coeff_q;
		endcase
	end

	// Shared multiplier operands
	always_comb begin
		case (state_q)
			S_W1F: begin
				mul_a = $signed(stgd_pkg::MUL_A_W'(rf_q));
				mul_b = $signed(stgd_pkg::MUL_B_W'(transient_amount_q));
			end
			S_W2F: begin
				mul_a = $signed(stgd_pkg::MUL_A_W'(stgd_pkg::K_FULL));
				mul_b = prod_q[stgd_pkg::MUL_B_W-1:0];
			end
			S_W1L: begin
				mul_a = $signed(stgd_pkg::MUL_A_W'(rl_q));
				mul_b = $signed(stgd_pkg::MUL_B_W'(punch_amount_q));
			end
			S_W2L: begin
				mul_a = $signed(stgd_pkg::MUL_A_W'(stgd_pkg::K_LOW));
				mul_b = prod_q[stgd_pkg::MUL_B_W-1:0];
			end
			default: begin
				mul_a = $signed({1'b0, coeff});
				mul_b = delta;
			end
		endcase
	end

	// Level update: arithmetic shift is the floor of the scaled product
	always_comb begin
		upd       = stgd_pkg::UPD_W'(prod_q >>> stgd_pkg::COEFF_FRAC_BITS);
		new_level = stgd_pkg::SUM_W'(level) + stgd_pkg::SUM_W'(upd);
		if (new_level[stgd_pkg::SUM_W-1]) begin
			env_sat = '0;
		end else if (|new_level[stgd_pkg::SUM_W-2:stgd_pkg::ENV_W]) begin
			env_sat = '1;
		end else begin
			env_sat = new_level[stgd_pkg::ENV_W-1:0];
		end
		if ((&new_level[stgd_pkg::SUM_W-1:stgd_pkg::ENV_W-1]) ||
		    !(|new_level[stgd_pkg::SUM_W-1:stgd_pkg::ENV_W-1])) begin
			lp_sat = new_level[stgd_pkg::ENV_W-1:0];
		end else if (new_level[stgd_pkg::SUM_W-1]) begin
			lp_sat = {1'b1, {(stgd_pkg::ENV_W-1){1'b0}}};
		end else begin
			lp_sat = {1'b0, {(stgd_pkg::ENV_W-1){1'b1}}};
		end
	end

	always_comb begin
		total    = (stgd_pkg::WSUM_W + 1)'(wsum_q)
		         + (stgd_pkg::WSUM_W + 1)'(prod_q[stgd_pkg::WSUM_W-1:0]);
		gain_raw = (stgd_pkg::WSUM_W - stgd_pkg::GAIN_SHIFT + 1)'(stgd_pkg::GAIN_ONE)
		         + total[stgd_pkg::WSUM_W:stgd_pkg::GAIN_SHIFT];
	end

	always_comb begin
		div_req.start = (state_q == S_DIV_START);
		div_req.fast  = div_low_q ? env_low_fast_q : env_full_fast_q;
		div_req.slow  = div_low_q ? env_low_slow_q : env_full_slow_q;
	end

	stgd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_attack_q      <= stgd_pkg::COEFF_W'(850600);
			fast_release_q     <= stgd_pkg::COEFF_W'(12479);
			slow_attack_q      <= stgd_pkg::COEFF_W'(17468);
			slow_release_q     <= stgd_pkg::COEFF_W'(2496);
			lowpass_coeff_q    <= stgd_pkg::COEFF_W'(646100);
			punch_amount_q     <= '0;
			transient_amount_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				stgd_pkg::REG_FAST_ATTACK:  fast_attack_q      <= pwdata[stgd_pkg::COEFF_W-1:0];
				stgd_pkg::REG_FAST_RELEASE: fast_release_q     <= pwdata[stgd_pkg::COEFF_W-1:0];
				stgd_pkg::REG_SLOW_ATTACK:  slow_attack_q      <= pwdata[stgd_pkg::COEFF_W-1:0];
				stgd_pkg::REG_SLOW_RELEASE: slow_release_q     <= pwdata[stgd_pkg::COEFF_W-1:0];
				stgd_pkg::REG_LOWPASS:      lowpass_coeff_q    <= pwdata[stgd_pkg::COEFF_W-1:0];
				stgd_pkg::REG_PUNCH:        punch_amount_q     <= pwdata[stgd_pkg::AMT_W-1:0];
				stgd_pkg::REG_TRANSIENT:    transient_amount_q <= pwdata[stgd_pkg::AMT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sel_q           <= F_FULL_FAST;
			div_low_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			env_full_fast_q <= '0;
			env_full_slow_q <= '0;
			env_low_fast_q  <= '0;
			env_low_slow_q  <= '0;
			lowpass_level_q <= '0;
			mag_q           <= '0;
			mid_q           <= '0;
			prod_q          <= '0;
			wsum_q          <= '0;
			rf_q            <= '0;
			rl_q            <= '0;
			gain_q          <= '0;
		end else begin
			// the gain stage refills the output register itself
			if (out_valid_q && out_ready && (state_q != S_GAIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						mag_q   <= {((abs_l > abs_r) ? abs_l : abs_r), 16'h0000};
						mid_q   <= {lr_sum, 15'h0000};
						sel_q   <= F_FULL_FAST;
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_FACC;
				end
				S_FACC: begin
					case (sel_q)
						F_FULL_FAST: env_full_fast_q <= env_sat;
						F_FULL_SLOW: env_full_slow_q <= env_sat;
						F_LOWPASS:   lowpass_level_q <= lp_sat;
						F_LOW_FAST:  env_low_fast_q  <= env_sat;
						default:     env_low_slow_q  <= env_sat;
					endcase
					if (sel_q == F_LOW_SLOW) begin
						div_low_q <= 1'b0;
						state_q   <= S_DIV_START;
					end else begin
						sel_q   <= filt_t'(sel_q + 3'd1);
						state_q <= S_FMUL;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (div_low_q) begin
							rl_q    <= div_rsp.ratio;
							state_q <= S_W1F;
						end else begin
							rf_q      <= div_rsp.ratio;
							div_low_q <= 1'b1;
							state_q   <= S_DIV_START;
						end
					end
				end
				S_W1F: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_W2F;
				end
				S_W2F: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_W1L;
				end
				S_W1L: begin
					wsum_q  <= prod_q[stgd_pkg::WSUM_W-1:0];
					prod_q  <= mul_a * mul_b;
					state_q <= S_W2L;
				end
				S_W2L: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					// hold until the previous gain has been taken
					if (!out_valid_q || out_ready) begin
						if (gain_raw > (stgd_pkg::WSUM_W - stgd_pkg::GAIN_SHIFT + 1)'(stgd_pkg::GAIN_MAX)) begin
							gain_q <= stgd_pkg::GAIN_MAX;
						end else begin
							gain_q <= gain_raw[stgd_pkg::GAIN_W-1:0];
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/stgd_checker.sv =====
module stgd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [stgd_pkg::GAIN_W-1:0] gain,
	input logic                        pready
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gain))
		else $error("gain changed or dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain >= stgd_pkg::GAIN_ONE && gain <= stgd_pkg::GAIN_MAX)
		else $error("gain outside 1.0 to 2.2");

	// in_ready stays low while the filter updates run after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken again too soon");

	// a new result only appears once the block is done with its item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while item still in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind stereo_transient_gain_detector stgd_checker u_stgd_checker (.*);

// ===== bench/tb_stereo_transient_gain_detector.sv =====
`timescale 1ns / 1ps

module tb_stereo_transient_gain_detector;

	localparam int     HALF_PERIOD   = 4;
	localparam int     RESET_CYCLES  = 6;
	localparam int     STALL_LIMIT   = 3000;
	localparam int     TAIL_CYCLES   = 80;
	localparam int     RANDOM_PHASES = 8;
	localparam int     PHASE_PAIRS   = 192;
	localparam int     MAX_REPORTS   = 200;
	localparam int     N_DIRECTED    = 34;
	localparam int     REG_UNMAPPED  = 7;
	localparam longint LEVEL_OFFSET  = 42949673;   // 0.02 in Q1.31
	localparam longint RATIO_CAP     = 98304;      // 1.5 in Q.16
	localparam longint W_FULL        = 58982;      // 0.9 in Q.16
	localparam longint W_LOW         = 72090;      // 1.1 in Q.16
	localparam longint UNITY_GAIN    = 16384;
	localparam longint GAIN_CAP      = 36045;
	localparam longint LEVEL_TOP     = 64'sh0000_0000_FFFF_FFFF;
	localparam longint MID_LO        = -64'sd2147483648;
	localparam longint MID_HI        = 64'sd2147483647;

	typedef enum int {ROW_WRITE, ROW_PAIR} row_kind_t;
	typedef enum int {SEG_HIT, SEG_QUIET, SEG_NOISE, SEG_EXTREME, SEG_LEVEL} seg_kind_t;
	typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

	typedef struct {
		row_kind_t                            kind;
		int                                   reg_sel;
		logic [stgd_pkg::PDATA_W-1:0]         wdata;
		logic signed [stgd_pkg::SAMPLE_W-1:0] l;
		logic signed [stgd_pkg::SAMPLE_W-1:0] r;
		bit                                   typed;
		logic [stgd_pkg::GAIN_W-1:0]          gain_ref;
	} stim_row_t;

	logic                                 clk          = 1'b0;
	logic                                 arst_n       = 1'b0;
	logic                                 in_valid     = 1'b0;
	logic                                 in_ready;
	logic signed [stgd_pkg::SAMPLE_W-1:0] left_sample  = '0;
	logic signed [stgd_pkg::SAMPLE_W-1:0] right_sample = '0;
	logic                                 out_valid;
	logic                                 out_ready    = 1'b0;
	logic [stgd_pkg::GAIN_W-1:0]          gain;
	logic                                 psel         = 1'b0;
	logic                                 penable      = 1'b0;
	logic                                 pwrite       = 1'b0;
	logic [stgd_pkg::PADDR_W-1:0]         paddr        = '0;
	logic [stgd_pkg::PDATA_W-1:0]         pwdata       = '0;
	logic [stgd_pkg::PDATA_W-1:0]         prdata;
	logic                                 pready;

	// shadow registers and detector state
	logic [stgd_pkg::COEFF_W-1:0]      atk_fast    = 24'd850600;
	logic [stgd_pkg::COEFF_W-1:0]      rel_fast    = 24'd12479;
	logic [stgd_pkg::COEFF_W-1:0]      atk_slow    = 24'd17468;
	logic [stgd_pkg::COEFF_W-1:0]      rel_slow    = 24'd2496;
	logic [stgd_pkg::COEFF_W-1:0]      lp_coeff    = 24'd646100;
	logic [stgd_pkg::AMT_W-1:0]        punch_amt   = '0;
	logic [stgd_pkg::AMT_W-1:0]        trans_amt   = '0;
	logic [stgd_pkg::ENV_W-1:0]        full_fast   = '0;
	logic [stgd_pkg::ENV_W-1:0]        full_slow   = '0;
	logic [stgd_pkg::ENV_W-1:0]        low_fast    = '0;
	logic [stgd_pkg::ENV_W-1:0]        low_slow    = '0;
	logic signed [stgd_pkg::ENV_W-1:0] lowpass_mid = '0;

	logic [stgd_pkg::GAIN_W-1:0] pending_gains[$];
	logic [stgd_pkg::GAIN_W-1:0] want_gain;
	stim_row_t                   directed_rows [N_DIRECTED];
	int                          mismatches   = 0;
	int                          quiet_cycles = 0;
	int                          burst_left   = 0;
	bit                          no_gaps      = 1'b0;
	bit                          input_held   = 1'b0;
	rx_mode_t                    rx_mode      = RX_OPEN;
	int                          mode_left    = 0;
	int                          stall_left   = 0;

	stereo_transient_gain_detector i_dut (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [stgd_pkg::ENV_W-1:0] follow_level(
			logic [stgd_pkg::ENV_W-1:0] lvl, longint target,
			logic [stgd_pkg::COEFF_W-1:0] atk, logic [stgd_pkg::COEFF_W-1:0] rel);
		longint cur, coeff, nxt;
		cur = lvl;
		coeff = (target > cur) ? atk : rel;
		nxt = cur + ((coeff * (target - cur)) >>> stgd_pkg::COEFF_FRAC_BITS);
		if (nxt < 0)
			nxt = 0;
		if (nxt > LEVEL_TOP)
			nxt = LEVEL_TOP;
		return nxt[stgd_pkg::ENV_W-1:0];
	endfunction

	function automatic longint ratio_q16(logic [stgd_pkg::ENV_W-1:0] fast,
			logic [stgd_pkg::ENV_W-1:0] slow);
		longint diff, den, q;
		diff = (fast > slow) ? longint'(fast) - longint'(slow) : 0;
		den = longint'(slow) + LEVEL_OFFSET;
		q = (diff <<< 16) / den;
		return (q > RATIO_CAP) ? RATIO_CAP : q;
	endfunction

	// advance the detector state by one pair and return its gain
	function automatic logic [stgd_pkg::GAIN_W-1:0] step_gain(
			logic signed [stgd_pkg::SAMPLE_W-1:0] l,
			logic signed [stgd_pkg::SAMPLE_W-1:0] r);
		longint ls, rs, al, ar, mag, mid, lp, low_mag, rf, rl, wsum, g;
		ls = l;
		rs = r;
		al = (ls < 0) ? -ls : ls;
		ar = (rs < 0) ? -rs : rs;
		mag = ((al > ar) ? al : ar) * 65536;
		mid = (ls + rs) * 32768;
		full_fast = follow_level(full_fast, mag, atk_fast, rel_fast);
		full_slow = follow_level(full_slow, mag, atk_slow, rel_slow);
		lp = lowpass_mid;
		lp = lp + ((longint'(lp_coeff) * (mid - lp)) >>> stgd_pkg::COEFF_FRAC_BITS);
		if (lp < MID_LO)
			lp = MID_LO;
		if (lp > MID_HI)
			lp = MID_HI;
		lowpass_mid = lp[stgd_pkg::ENV_W-1:0];
		low_mag = (lp < 0) ? -lp : lp;
		low_fast = follow_level(low_fast, low_mag, atk_fast, rel_fast);
		low_slow = follow_level(low_slow, low_mag, atk_slow, rel_slow);
		rf = ratio_q16(full_fast, full_slow);
		rl = ratio_q16(low_fast, low_slow);
		wsum = longint'(trans_amt) * W_FULL * rf + longint'(punch_amt) * W_LOW * rl;
		g = UNITY_GAIN + (wsum >>> 33);
		if (g > GAIN_CAP)
			g = GAIN_CAP;
		return g[stgd_pkg::GAIN_W-1:0];
	endfunction

	function automatic stim_row_t reg_row(int idx, logic [stgd_pkg::PDATA_W-1:0] data);
		stim_row_t row;
		row = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t pair_row(logic signed [stgd_pkg::SAMPLE_W-1:0] l,
			logic signed [stgd_pkg::SAMPLE_W-1:0] r);
		stim_row_t row;
		row = '{ROW_PAIR, 0, '0, l, r, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t known_row(logic signed [stgd_pkg::SAMPLE_W-1:0] l,
			logic signed [stgd_pkg::SAMPLE_W-1:0] r, logic [stgd_pkg::GAIN_W-1:0] g);
		stim_row_t row;
		row = '{ROW_PAIR, 0, '0, l, r, 1'b1, g};
		return row;
	endfunction

	function automatic int jitter(int span);
		int v;
		v = $urandom_range(0, 2 * span);
		return v - span;
	endfunction

	function automatic int corner_sample();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return -32767;
		endcase
	endfunction

	function automatic logic signed [stgd_pkg::SAMPLE_W-1:0] clamp_sample(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[stgd_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic logic [stgd_pkg::PDATA_W-1:0] pick_coeff(int phase);
		if (phase == 0)
			return 32'hFFFF_FFFF;
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'h00FF_FFFF;
			2: return $urandom;
			default: return $urandom_range(1000, 1 << 20);
		endcase
	endfunction

	function automatic logic [stgd_pkg::PDATA_W-1:0] pick_amount(int phase);
		if (phase == 0)
			return 32'hFFFF_FFFF;
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd32768;
			2: return 32'd65535;
			3: return $urandom_range(0, 32768);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input int idx, input logic [stgd_pkg::PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= stgd_pkg::PADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			stgd_pkg::REG_FAST_ATTACK:  atk_fast = data[stgd_pkg::COEFF_W-1:0];
			stgd_pkg::REG_FAST_RELEASE: rel_fast = data[stgd_pkg::COEFF_W-1:0];
			stgd_pkg::REG_SLOW_ATTACK:  atk_slow = data[stgd_pkg::COEFF_W-1:0];
			stgd_pkg::REG_SLOW_RELEASE: rel_slow = data[stgd_pkg::COEFF_W-1:0];
			stgd_pkg::REG_LOWPASS:      lp_coeff = data[stgd_pkg::COEFF_W-1:0];
			stgd_pkg::REG_PUNCH:        punch_amt = data[stgd_pkg::AMT_W-1:0];
			stgd_pkg::REG_TRANSIENT:    trans_amt = data[stgd_pkg::AMT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pair(input logic signed [stgd_pkg::SAMPLE_W-1:0] l,
			input logic signed [stgd_pkg::SAMPLE_W-1:0] r, input bit typed,
			input logic [stgd_pkg::GAIN_W-1:0] typed_gain);
		int gap;
		logic [stgd_pkg::GAIN_W-1:0] predicted;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!no_gaps && $urandom_range(0, 4) != 0)
				gap = $urandom_range(1, 72);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		do @(posedge clk); while (!in_ready);
		predicted = step_gain(l, r);
		pending_gains.push_back(typed ? typed_gain : predicted);
		input_held = 1'b1;
	endtask

	// drop valid and wait until every gain has come back
	task automatic settle();
		if (input_held) begin
			in_valid <= 1'b0;
			input_held = 1'b0;
			@(posedge clk);
		end
		while (pending_gains.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_SLUGGISH));
			mode_left <= $urandom_range(200, 1500);
		end else begin
			mode_left <= mode_left - 1;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (rx_mode == RX_CHOPPY && $urandom_range(0, 1) == 0)
				stall_left <= $urandom_range(1, 6);
			else if (rx_mode == RX_SLUGGISH && $urandom_range(0, 39) == 0)
				stall_left <= $urandom_range(20, 120);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_gains.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: gain transfer with none expected, actual %0d", $time, gain);
				mismatches++;
			end else begin
				want_gain = pending_gains.pop_front();
				if (gain !== want_gain) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: gain mismatch, expected %0d, actual %0d",
							$time, want_gain, gain);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (psel && penable && pwrite && pready) || (in_valid && in_ready) ||
		    (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int pairs_left, seg_len, amp, sgn, spread, ls, rs;
		seg_kind_t seg;
		directed_rows = '{
			reg_row(stgd_pkg::REG_TRANSIENT, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_PUNCH, 32'hABCD_FFFF),
			known_row(-32768, -32768, 16'd36045),
			pair_row(32767, 32767),
			pair_row(0, 0),
			pair_row(0, 0),
			pair_row(32767, -32768),
			pair_row(-32768, 32767),
			pair_row(100, -100),
			reg_row(stgd_pkg::REG_TRANSIENT, 32'h7FFF_0000),
			reg_row(stgd_pkg::REG_PUNCH, 32'd0),
			known_row(32767, -32768, 16'd16384),
			known_row(-32768, -32768, 16'd16384),
			known_row(0, 0, 16'd16384),
			reg_row(stgd_pkg::REG_FAST_ATTACK, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_FAST_RELEASE, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_SLOW_ATTACK, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_SLOW_RELEASE, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_LOWPASS, 32'hFFFF_FFFF),
			reg_row(stgd_pkg::REG_TRANSIENT, 32'd32768),
			reg_row(stgd_pkg::REG_PUNCH, 32'd32768),
			reg_row(REG_UNMAPPED, 32'hFFFF_FFFF),
			pair_row(32767, 32767),
			pair_row(0, 0),
			pair_row(-32768, -32768),
			pair_row(16384, -16384),
			pair_row(-1, 1),
			reg_row(stgd_pkg::REG_FAST_ATTACK, 32'd0),
			reg_row(stgd_pkg::REG_FAST_RELEASE, 32'd0),
			reg_row(stgd_pkg::REG_SLOW_ATTACK, 32'd0),
			reg_row(stgd_pkg::REG_SLOW_RELEASE, 32'd0),
			reg_row(stgd_pkg::REG_LOWPASS, 32'd0),
			pair_row(32767, 32767),
			pair_row(-1, -1)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].wdata);
			end else begin
				send_pair(directed_rows[i].l, directed_rows[i].r, directed_rows[i].typed,
					directed_rows[i].gain_ref);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			for (int idx = stgd_pkg::REG_FAST_ATTACK; idx <= stgd_pkg::REG_TRANSIENT; idx++)
				write_reg(idx, (idx >= stgd_pkg::REG_PUNCH) ? pick_amount(phase) :
					pick_coeff(phase));
			no_gaps = (phase % 3 == 2);
			pairs_left = PHASE_PAIRS;
			// program-like material: hits, decays, silence, held levels, noise and corner values
			while (pairs_left > 0) begin
				seg = seg_kind_t'($urandom_range(SEG_HIT, SEG_LEVEL));
				seg_len = $urandom_range(4, 40);
				amp = $urandom_range(2000, 32768);
				sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
				spread = $urandom_range(1, 3);
				for (int k = 0; k < seg_len && pairs_left > 0; k++) begin
					case (seg)
						SEG_HIT: begin
							ls = sgn * amp + jitter(64);
							rs = sgn * amp / spread + jitter(64);
							amp = amp * 7 / 8;
						end
						SEG_QUIET: begin
							ls = jitter(256);
							rs = jitter(256);
						end
						SEG_NOISE: begin
							ls = jitter(32768);
							rs = jitter(32768);
						end
						SEG_EXTREME: begin
							ls = corner_sample();
							rs = corner_sample();
						end
						default: begin
							ls = sgn * amp;
							rs = (spread == 1) ? -sgn * amp : sgn * amp;
						end
					endcase
					send_pair(clamp_sample(ls), clamp_sample(rs), 1'b0, '0);
					pairs_left--;
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_gains.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
